/* rtl/sd256_pkg.sv */
// Shared types and constants for the signed 256-bit divider.
package sd256_pkg;

  localparam int unsigned NumBits = 256;
  localparam int unsigned CntW    = $clog2(NumBits);

  typedef struct packed {
    logic [63:0] dividend_limb0;
    logic [63:0] dividend_limb1;
    logic [63:0] dividend_limb2;
    logic [63:0] dividend_limb3;
    logic [63:0] divisor_limb0;
    logic [63:0] divisor_limb1;
    logic [63:0] divisor_limb2;
    logic [63:0] divisor_limb3;
  } sd256_in_t;

  typedef struct packed {
    logic [63:0] quotient_limb0;
    logic [63:0] quotient_limb1;
    logic [63:0] quotient_limb2;
    logic [63:0] quotient_limb3;
    logic [63:0] remainder_limb0;
    logic [63:0] remainder_limb1;
    logic [63:0] remainder_limb2;
    logic [63:0] remainder_limb3;
    logic        zero_divisor;
  } sd256_out_t;

  typedef struct packed {
    logic load;
    logic neg;
    logic step;
    logic fix;
    logic write;
  } sd256_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sd256_sts_t;

endpackage

/* rtl/sd256_dp.sv */
// Datapath: operand registers, restoring divide step, sign fixup, result register.
module sd256_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sd256_pkg::sd256_in_t  req,
  input  sd256_pkg::sd256_cmd_t cmd,
  output sd256_pkg::sd256_sts_t sts,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output sd256_pkg::sd256_out_t rsp
);
  import sd256_pkg::*;

  logic [NumBits-1:0] a;
  logic [NumBits-1:0] b;
  logic [NumBits-1:0] r;
  logic               aneg;
  logic               bneg;
  logic               bzero;

  logic [NumBits-1:0] a_in;
  logic [NumBits-1:0] b_in;
  logic [NumBits-1:0] r_sh;
  logic [NumBits:0]   diff;
  logic               ge;
  logic [NumBits-1:0] q_res;
  logic [NumBits-1:0] r_res;

  assign a_in = {req.dividend_limb3, req.dividend_limb2,
                 req.dividend_limb1, req.dividend_limb0};
  assign b_in = {req.divisor_limb3, req.divisor_limb2,
                 req.divisor_limb1, req.divisor_limb0};

  // partial remainder stays below the divisor magnitude, so the shift never overflows
  assign r_sh = {r[NumBits-2:0], a[NumBits-1]};
  assign diff = {1'b0, r_sh} - {1'b0, b};
  assign ge   = ~diff[NumBits];

  assign q_res = bzero ? '0 : a;
  assign r_res = bzero ? '0 : r;

  assign sts.out_busy = rsp_valid & rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a     <= a_in;
      b     <= b_in;
      r     <= '0;
      aneg  <= a_in[NumBits-1];
      bneg  <= b_in[NumBits-1];
      bzero <= (b_in == '0);
    end else if (cmd.neg) begin
      if (aneg) a <= ~a + NumBits'(1);
      if (bneg) b <= ~b + NumBits'(1);
    end else if (cmd.step) begin
      r <= ge ? diff[NumBits-1:0] : r_sh;
      a <= {a[NumBits-2:0], ge};
    end else if (cmd.fix) begin
      if (aneg != bneg) a <= ~a + NumBits'(1);
      if (aneg) r <= ~r + NumBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      rsp.quotient_limb0  <= q_res[63:0];
      rsp.quotient_limb1  <= q_res[127:64];
      rsp.quotient_limb2  <= q_res[191:128];
      rsp.quotient_limb3  <= q_res[255:192];
      rsp.remainder_limb0 <= r_res[63:0];
      rsp.remainder_limb1 <= r_res[127:64];
      rsp.remainder_limb2 <= r_res[191:128];
      rsp.remainder_limb3 <= r_res[255:192];
      rsp.zero_divisor    <= bzero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.write) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> rsp_valid)
    else $error("result beat missing after write");

  a_zero_results: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.zero_divisor) |->
      (rsp.quotient_limb0 == '0 && rsp.remainder_limb0 == '0))
    else $error("zero divisor beat carries nonzero result");

endmodule

/* rtl/sd256_ctrl.sv */
// Controller: sequences load, sign take-off, 256 divide steps, fixup and result write.
module sd256_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  sd256_pkg::sd256_sts_t sts,
  output sd256_pkg::sd256_cmd_t cmd
);
  import sd256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NEG   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FIX   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [CntW-1:0] count;
  logic            last_step;

  assign req_stall = (state != S_IDLE);
  assign last_step = (count == CntW'(NumBits - 1));

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_NEG;
        end
      end
      S_NEG: begin
        cmd.neg    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (last_step) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (!sts.out_busy) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        count <= count + CntW'(1);
      end else begin
        count <= '0;
      end
    end
  end

  a_accept_neg: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_NEG))
    else $error("accepted beat not followed by sign stage");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && last_step) |=> (state == S_FIX))
    else $error("divide loop did not end after last step");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_DIV) |-> (count == '0))
    else $error("step counter not cleared outside divide loop");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !sts.out_busy)
    else $error("result written over a stalled beat");

endmodule

/* rtl/signed_256bit_divider.sv */
// Signed 256-bit divider top level: quotient truncated toward zero, remainder with dividend sign.
// An accepted input beat is loaded, then runs sign take-off, the divide steps, sign fixup
// and result write; no new input beat is taken until the write. The 256 one-bit restoring
// steps use a single 257-bit subtractor; the write waits while a result beat is stalled.
// A finished result waits in the output register while the next input beat is taken.
// Reset (synchronous, active high) returns the controller to idle and drops the output valid.
module signed_256bit_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  sd256_pkg::sd256_in_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output sd256_pkg::sd256_out_t rsp
);
  import sd256_pkg::*;

  sd256_cmd_t cmd;
  sd256_sts_t sts;

  sd256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sd256_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* tb/tb_signed_256bit_divider.sv */
// Self-checking testbench for the signed 256-bit divider: directed and random beats checked.
module tb_signed_256bit_divider;
  import sd256_pkg::*;

  localparam logic [255:0] MostNeg = {1'b1, 255'b0};
  localparam logic [255:0] MostPos = {1'b0, {255{1'b1}}};
  localparam int QuietLimit = 6000;
  localparam int HoldCycles = 1500;
  localparam int DrainCycles = 300;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  sd256_in_t  req;
  logic       rsp_valid;
  logic       rsp_stall;
  sd256_out_t rsp;

  sd256_out_t divisions_in_flight[$];
  int         mismatches;
  int         quiet_cycles;
  int         rsp_hold_cycles;
  bit         sender_gaps;
  bit         receiver_stalls;

  signed_256bit_divider dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Truncating signed divide on magnitudes; most negative magnitude is 2^255 unsigned.
  function automatic sd256_out_t divide_trunc(sd256_in_t op);
    logic [255:0] num, den, mag_num, mag_den, quo, rem;
    sd256_out_t   res;
    num = {op.dividend_limb3, op.dividend_limb2, op.dividend_limb1, op.dividend_limb0};
    den = {op.divisor_limb3, op.divisor_limb2, op.divisor_limb1, op.divisor_limb0};
    res = '0;
    if (den == '0) begin
      res.zero_divisor = 1'b1;
      return res;
    end
    mag_num = num[255] ? -num : num;
    mag_den = den[255] ? -den : den;
    quo = mag_num / mag_den;
    rem = mag_num % mag_den;
    if (num[255] ^ den[255]) quo = -quo;
    if (num[255]) rem = -rem;
    res.quotient_limb0  = quo[63:0];
    res.quotient_limb1  = quo[127:64];
    res.quotient_limb2  = quo[191:128];
    res.quotient_limb3  = quo[255:192];
    res.remainder_limb0 = rem[63:0];
    res.remainder_limb1 = rem[127:64];
    res.remainder_limb2 = rem[191:128];
    res.remainder_limb3 = rem[255:192];
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic void check_division(sd256_out_t exp_r, sd256_out_t act_r);
    check_field("quotient_limb0", exp_r.quotient_limb0, act_r.quotient_limb0);
    check_field("quotient_limb1", exp_r.quotient_limb1, act_r.quotient_limb1);
    check_field("quotient_limb2", exp_r.quotient_limb2, act_r.quotient_limb2);
    check_field("quotient_limb3", exp_r.quotient_limb3, act_r.quotient_limb3);
    check_field("remainder_limb0", exp_r.remainder_limb0, act_r.remainder_limb0);
    check_field("remainder_limb1", exp_r.remainder_limb1, act_r.remainder_limb1);
    check_field("remainder_limb2", exp_r.remainder_limb2, act_r.remainder_limb2);
    check_field("remainder_limb3", exp_r.remainder_limb3, act_r.remainder_limb3);
    check_field("zero_divisor", {63'b0, exp_r.zero_divisor}, {63'b0, act_r.zero_divisor});
  endfunction

  // Beat monitor, result checker and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (divisions_in_flight.size() == 0) begin
          $error("result beat with no division pending");
          mismatches++;
        end else begin
          check_division(divisions_in_flight.pop_front(), rsp);
        end
      end
      if (req_valid && !req_stall) begin
        divisions_in_flight = {divisions_in_flight, divide_trunc(req)};
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("[signed_256bit_divider] ERROR");
          $finish;
        end
      end
    end
  end

  // Result side: random stall bursts, plus a long hold when requested.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (rsp_hold_cycles) @(negedge clk);
        rsp_hold_cycles = 0;
        rsp_stall <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic issue_division(logic [255:0] num, logic [255:0] den);
    sd256_in_t beat;
    int        gap;
    beat.dividend_limb0 = num[63:0];
    beat.dividend_limb1 = num[127:64];
    beat.dividend_limb2 = num[191:128];
    beat.dividend_limb3 = num[255:192];
    beat.divisor_limb0  = den[63:0];
    beat.divisor_limb1  = den[127:64];
    beat.divisor_limb2  = den[191:128];
    beat.divisor_limb3  = den[255:192];
    gap = (sender_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= beat;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic logic [255:0] rand_wide();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    int unsigned  w;
    v = rand_wide();
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = 256'd1;
      2: v = '1;
      3: v = $urandom_range(0, 1) ? MostNeg : MostPos;
      4: v = 256'd1 << $urandom_range(0, 255);
      5, 6: ;
      default: begin
        w = $urandom_range(1, 255);
        v = v & ((256'd1 << w) - 256'd1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic test_extremes();
    issue_division(MostPos, 256'd1);
    issue_division(MostPos, MostPos);
    issue_division(MostNeg, MostNeg);
    issue_division(MostNeg, MostPos);
    issue_division(MostPos, MostNeg);
    issue_division('0, MostNeg);
    issue_division(MostNeg, 256'd1);
    issue_division(256'd1, MostPos);
  endtask

  task automatic test_signs();
    issue_division(256'd7, 256'd2);
    issue_division(-256'd7, 256'd2);
    issue_division(256'd7, -256'd2);
    issue_division(-256'd7, -256'd2);
    issue_division(MostNeg, '1);
    issue_division('1, '1);
    issue_division(256'd5, 256'd7);
    issue_division(-256'd5, 256'd7);
  endtask

  task automatic test_zero_divisor();
    issue_division('0, '0);
    issue_division(MostNeg, '0);
    issue_division('1, '0);
    issue_division(rand_wide(), '0);
  endtask

  // Power-of-two, 64-bit and 128-bit divisors.
  task automatic test_narrow_divisors();
    issue_division(rand_wide(), 256'd1 << $urandom_range(1, 254));
    issue_division(rand_wide(), rand_wide() >> 192);
    issue_division(rand_wide(), rand_wide() >> 128);
  endtask

  task automatic test_backpressure();
    rsp_hold_cycles = HoldCycles;
    repeat (6) issue_division(rand_wide(), rand_operand());
  endtask

  task automatic test_random(int count);
    logic [255:0] den;
    repeat (count) begin
      den = rand_operand();
      if ($urandom_range(0, 11) == 0) issue_division($urandom_range(0, 1) ? den : -den, den);
      else issue_division(rand_operand(), den);
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mismatches = 0;
    quiet_cycles = 0;
    rsp_hold_cycles = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_signs();
    test_zero_divisor();
    test_narrow_divisors();
    test_backpressure();
    test_random(880);
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    test_random(120);

    @(negedge clk);
    req_valid <= 1'b0;
    while (divisions_in_flight.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[signed_256bit_divider] OK");
    end else begin
      $display("[signed_256bit_divider] ERROR");
    end
    $finish;
  end

endmodule
